@@ sv/obh_pkg.sv @@
// Shared types and constants for the owner bucket histogram.
// Used by the divider, the counter memory and the top level; depends on nothing.
package obh_pkg;

  localparam int unsigned OWNER_W = 6;
  localparam int unsigned LIMIT_W = 7;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned BIN_W   = 32;
  localparam int unsigned STEP_W  = $clog2(OWNER_W);

  localparam logic REG_SLAB_SIZE   = 1'b0;
  localparam logic REG_OWNER_LIMIT = 1'b1;

  localparam logic CMD_COUNT = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef struct packed {
    logic               done;
    logic               ovf;
    logic [OWNER_W-1:0] quo;
  } div_res_t;

  typedef struct packed {
    logic               rd_en;
    logic               wr_en;
    logic               clr_en;
    logic [OWNER_W-1:0] addr;
    logic [COUNT_W-1:0] wr_data;
  } mem_req_t;

endpackage

@@ sv/obh_divider.sv @@
// Bit-serial restoring divider that yields a six-bit owner index or an overflow flag.
// Depends on obh_pkg.
module obh_divider (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [obh_pkg::BIN_W-1:0]    bin,
  input  logic [obh_pkg::COUNT_W-1:0]  slab,
  output obh_pkg::div_res_t            res
);

  localparam int unsigned DW = obh_pkg::BIN_W + obh_pkg::OWNER_W;

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic                          ovf_r, ovf_nxt;
  logic [obh_pkg::STEP_W-1:0]    step_r, step_nxt;
  logic [obh_pkg::BIN_W-1:0]     rem_r, rem_nxt;
  logic [DW-1:0]                 den_r, den_nxt;
  logic [obh_pkg::OWNER_W-1:0]   quo_r, quo_nxt;
  logic                          fits;

  assign fits = {{obh_pkg::OWNER_W{1'b0}}, rem_r} >= den_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    ovf_nxt  = ovf_r;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      ovf_nxt  = (slab == '0) ||
                 ({{obh_pkg::OWNER_W{1'b0}}, bin} >= {slab, {obh_pkg::OWNER_W{1'b0}}});
      step_nxt = '0;
      rem_nxt  = bin;
      den_nxt  = {1'b0, slab, {(obh_pkg::OWNER_W - 1){1'b0}}};
      quo_nxt  = '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = rem_r - den_r[obh_pkg::BIN_W-1:0];
      end
      quo_nxt  = {quo_r[obh_pkg::OWNER_W-2:0], fits};
      den_nxt  = den_r >> 1;
      step_nxt = step_r + 1'b1;
      if (step_r == obh_pkg::STEP_W'(obh_pkg::OWNER_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    ovf_r  <= ovf_nxt;
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quo_r  <= quo_nxt;
  end

  assign res.done = done_r;
  assign res.ovf  = ovf_r;
  assign res.quo  = quo_r;

endmodule

@@ sv/obh_counter_mem.sv @@
// Counter memory with a registered read port and per-entry valid bits.
// An entry that is not valid reads as zero. Depends on obh_pkg.
module obh_counter_mem #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  obh_pkg::mem_req_t            req,
  output logic [obh_pkg::COUNT_W-1:0]  rd_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [obh_pkg::COUNT_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]            vld_r;
  logic [obh_pkg::COUNT_W-1:0] rd_data_r;
  logic                        rd_hit_r;
  logic [AW-1:0]               addr;

  assign addr = req.addr[AW-1:0];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[addr] <= 1'b1;
      end
      if (req.clr_en) begin
        vld_r[addr] <= 1'b0;
      end
      if (req.rd_en) begin
        rd_hit_r <= vld_r[addr];
      end
    end
  end

  assign rd_data = rd_hit_r ? rd_data_r : '0;

endmodule

@@ sv/owner_bucket_histogram_unit.sv @@
// A count item whose owner is counted passes the divider, the limit check, the counter
// read and the counter write-back before the next item can be taken. The bit-serial divider
// produces one owner bit per cycle, and the quotient is checked against the limits when the
// divider finishes. The counter memory then reads the counter and writes it back plus one,
// and the idle state accepts the next item. A dropped record skips the memory. A flush item
// emits the counters in order, each with one memory read, then the output register load
// when the output side is ready. The next item can be taken once the last counter has been
// loaded. The counters are zero after reset and after each flush, with no clearing pass.
// Depends on obh_pkg, obh_divider and obh_counter_mem.
module owner_bucket_histogram_unit #(
  parameter int unsigned NUM_OWNERS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [31:0]                   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic [obh_pkg::BIN_W-1:0]     in_bin_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [obh_pkg::OWNER_W-1:0]   out_owner_index,
  output logic [obh_pkg::COUNT_W-1:0]   out_owner_count,
  output logic                          out_last
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_DIV     = 3'd1;
  localparam logic [2:0] ST_CNT_RD  = 3'd2;
  localparam logic [2:0] ST_CNT_WR  = 3'd3;
  localparam logic [2:0] ST_FL_RD   = 3'd4;
  localparam logic [2:0] ST_FL_WAIT = 3'd5;

  localparam logic [obh_pkg::OWNER_W-1:0] LAST_IDX = obh_pkg::OWNER_W'(NUM_OWNERS - 1);
  localparam logic [obh_pkg::LIMIT_W-1:0] TABLE_SZ = obh_pkg::LIMIT_W'(NUM_OWNERS);

  logic [2:0]                    state_r, state_nxt;
  logic [obh_pkg::COUNT_W-1:0]   slab_size_r;
  logic [obh_pkg::LIMIT_W-1:0]   owner_limit_r;
  logic [obh_pkg::OWNER_W-1:0]   idx_r, idx_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [obh_pkg::OWNER_W-1:0]   out_idx_r, out_idx_nxt;
  logic [obh_pkg::COUNT_W-1:0]   out_count_r, out_count_nxt;
  logic                          out_last_r, out_last_nxt;
  logic                          accept;
  logic                          div_start;
  logic                          hit;
  logic                          out_free;
  obh_pkg::div_res_t             div_res;
  obh_pkg::mem_req_t             mreq;
  logic [obh_pkg::COUNT_W-1:0]   rd_data;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign div_start = accept && (in_cmd == obh_pkg::CMD_COUNT);
  assign out_free = !out_valid_r || out_ready;
  assign hit = !div_res.ovf &&
               ({1'b0, div_res.quo} < owner_limit_r) &&
               ({1'b0, div_res.quo} < TABLE_SZ);

  obh_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .bin   (in_bin_index),
    .slab  (slab_size_r),
    .res   (div_res)
  );

  obh_counter_mem #(
    .DEPTH (NUM_OWNERS)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mreq),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_idx_nxt   = out_idx_r;
    out_count_nxt = out_count_r;
    out_last_nxt  = out_last_r;
    mreq          = '0;
    mreq.addr     = idx_r;
    mreq.wr_data  = rd_data + 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd == obh_pkg::CMD_FLUSH) begin
            idx_nxt   = '0;
            state_nxt = ST_FL_RD;
          end else begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          idx_nxt   = div_res.quo;
          state_nxt = hit ? ST_CNT_RD : ST_IDLE;
        end
      end
      ST_CNT_RD: begin
        mreq.rd_en = 1'b1;
        state_nxt  = ST_CNT_WR;
      end
      ST_CNT_WR: begin
        mreq.wr_en = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_FL_RD: begin
        mreq.rd_en = 1'b1;
        state_nxt  = ST_FL_WAIT;
      end
      ST_FL_WAIT: begin
        if (out_free) begin
          mreq.clr_en   = 1'b1;
          out_valid_nxt = 1'b1;
          out_idx_nxt   = idx_r;
          out_count_nxt = rd_data;
          out_last_nxt  = (idx_r == LAST_IDX);
          if (idx_r == LAST_IDX) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_FL_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      slab_size_r   <= 32'd1;
      owner_limit_r <= obh_pkg::LIMIT_W'(64);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && (cfg_index == obh_pkg::REG_SLAB_SIZE)) begin
        slab_size_r <= cfg_wdata;
      end
      if (cfg_we && (cfg_index == obh_pkg::REG_OWNER_LIMIT)) begin
        owner_limit_r <= cfg_wdata[obh_pkg::LIMIT_W-1:0];
      end
    end
    idx_r       <= idx_nxt;
    out_idx_r   <= out_idx_nxt;
    out_count_r <= out_count_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_owner_index = out_idx_r;
  assign out_owner_count = out_count_r;
  assign out_last        = out_last_r;

`ifndef NO_ASSERTIONS
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == ST_DIV))
    else $error("Divider finished outside the divide state.");

  a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_owner_index == LAST_IDX))
    else $error("Last flag on an item that is not the final counter.");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("Input accepted again before the previous item finished.");
`endif

endmodule

@@ bench/tb_owner_bucket_histogram_unit.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for owner_bucket_histogram_unit: random items with random gaps,
// a per-owner tally predicts every flush result. Depends on obh_pkg and the unit itself.
module tb_owner_bucket_histogram_unit;
  import obh_pkg::*;

  localparam int NUM_OWNERS     = 64;
  localparam int SETTLE_CYCLES  = 30;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic             cmd;
    logic [BIN_W-1:0] bin;
  } hist_item_t;

  typedef struct packed {
    logic [OWNER_W-1:0] idx;
    logic [COUNT_W-1:0] count;
    logic               last;
  } owner_result_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic                 cfg_index = REG_SLAB_SIZE;
  logic [31:0]          cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_cmd = CMD_COUNT;
  logic [BIN_W-1:0]     in_bin_index = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [OWNER_W-1:0]   out_owner_index;
  logic [COUNT_W-1:0]   out_owner_count;
  logic                 out_last;

  hist_item_t           pending_items[$];
  owner_result_t        owed_results[$];
  logic [COUNT_W-1:0]   owner_tally[NUM_OWNERS];
  logic [31:0]          cur_slab = 32'd1;
  logic [LIMIT_W-1:0]   cur_limit = LIMIT_W'(64);
  int unsigned          items_queued = 0;
  int unsigned          items_taken = 0;
  int unsigned          mismatches = 0;
  int unsigned          send_gap = 0;
  int unsigned          stall_left = 0;
  int unsigned          hold_left = 0;
  int unsigned          idle_cycles = 0;
  bit                   burst = 1'b0;
  bit                   hold_req = 1'b0;
  bit                   hold_done = 1'b0;

  owner_bucket_histogram_unit #(
    .NUM_OWNERS(NUM_OWNERS)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_cmd(in_cmd),
    .in_bin_index(in_bin_index),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_owner_index(out_owner_index),
    .out_owner_count(out_owner_count),
    .out_last(out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < NUM_OWNERS; i++) begin
      owner_tally[i] = '0;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  task automatic tally_item(input logic cmd, input logic [BIN_W-1:0] bin);
    logic [31:0]   owner;
    owner_result_t res;
    if (cmd == CMD_COUNT) begin
      owner = (cur_slab == 0) ? 32'hFFFF_FFFF : bin / cur_slab;
      if (owner < 32'(cur_limit) && owner < 32'(NUM_OWNERS)) begin
        owner_tally[owner[OWNER_W-1:0]] = owner_tally[owner[OWNER_W-1:0]] + 1'b1;
      end
    end else begin
      for (int i = 0; i < NUM_OWNERS; i++) begin
        res.idx   = OWNER_W'(i);
        res.count = owner_tally[i];
        res.last  = (i == NUM_OWNERS - 1);
        owed_results.push_back(res);
        owner_tally[i] = '0;
      end
    end
  endtask

  task automatic flag_error(input string msg);
    if (mismatches < 10) begin
      $display("mismatch: %s", msg);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    hist_item_t item;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        tally_item(in_cmd, in_bin_index);
        items_taken++;
      end
      if (in_valid && !in_ready) begin
        in_valid <= 1'b1;
      end else if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        item = pending_items.pop_front();
        in_valid     <= 1'b1;
        in_cmd       <= item.cmd;
        in_bin_index <= item.bin;
        send_gap = burst ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    owner_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          flag_error($sformatf("unexpected result idx=%0d count=%0d last=%0b",
                               out_owner_index, out_owner_count, out_last));
        end else begin
          want = owed_results.pop_front();
          if (out_owner_index != want.idx || out_owner_count != want.count ||
              out_last != want.last) begin
            flag_error($sformatf("idx %0d/%0d count %0d/%0d last %0b/%0b (expected/actual)",
                                 want.idx, out_owner_index, want.count, out_owner_count,
                                 want.last, out_last));
          end
        end
      end
      if (hold_req && !hold_done && out_valid) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left = burst ? 0 : pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_item(input logic cmd, input logic [BIN_W-1:0] bin);
    hist_item_t item;
    item.cmd = cmd;
    item.bin = bin;
    pending_items.push_back(item);
    items_queued++;
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == REG_SLAB_SIZE) begin
      cur_slab = value;
    end else begin
      cur_limit = value[LIMIT_W-1:0];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    while (items_taken != items_queued || owed_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [BIN_W-1:0] pick_bin();
    logic [63:0] base;
    logic [6:0]  who;
    if ($urandom_range(0, 3) == 0 || cur_slab == 0) begin
      return $urandom();
    end
    who  = 7'($urandom_range(0, 64));
    base = 64'(who) * 64'(cur_slab) + 64'($urandom_range(0, cur_slab - 1));
    if (base > 64'hFFFF_FFFF) begin
      return $urandom();
    end
    return base[BIN_W-1:0];
  endfunction

  task automatic queue_random(input int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 24) == 0) begin
        queue_item(CMD_FLUSH, $urandom());
      end else begin
        queue_item(CMD_COUNT, pick_bin());
      end
    end
    queue_item(CMD_FLUSH, $urandom());
  endtask

  initial begin
    logic [31:0] slab_set[8];
    logic [31:0] limit_set[8];
    slab_set  = '{32'd1, 32'd7, 32'h0400_0000, 32'd1000, 32'hFFFF_FFFF, 32'd3,
                  32'($urandom_range(1, 100)), 32'h8000_0000};
    limit_set = '{32'd64, 32'd50, 32'd64, 32'd127, 32'd2, 32'd1,
                  32'($urandom_range(0, 127)), 32'd64};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    queue_item(CMD_COUNT, 32'd0);
    queue_item(CMD_COUNT, 32'd63);
    queue_item(CMD_COUNT, 32'd64);
    queue_item(CMD_COUNT, 32'hFFFF_FFFF);
    queue_item(CMD_COUNT, 32'd5);
    queue_item(CMD_COUNT, 32'd5);
    queue_item(CMD_FLUSH, 32'hFFFF_FFFF);
    queue_item(CMD_FLUSH, 32'd0);
    settle();

    write_reg(REG_SLAB_SIZE, 32'd0);
    queue_item(CMD_COUNT, 32'd0);
    queue_item(CMD_COUNT, 32'd12345);
    queue_item(CMD_FLUSH, 32'd0);
    settle();

    write_reg(REG_SLAB_SIZE, 32'hFFFF_FFFF);
    write_reg(REG_OWNER_LIMIT, 32'd127);
    queue_item(CMD_COUNT, 32'hFFFF_FFFE);
    queue_item(CMD_COUNT, 32'hFFFF_FFFF);
    queue_item(CMD_FLUSH, 32'd0);
    settle();

    write_reg(REG_SLAB_SIZE, 32'd3);
    write_reg(REG_OWNER_LIMIT, 32'd0);
    queue_item(CMD_COUNT, 32'd0);
    queue_item(CMD_COUNT, 32'd5);
    queue_item(CMD_FLUSH, 32'd0);
    settle();

    for (int p = 0; p < 8; p++) begin
      write_reg(REG_SLAB_SIZE, slab_set[p]);
      write_reg(REG_OWNER_LIMIT, limit_set[p]);
      burst = (p % 3 == 1);
      if (p == 2) begin
        hold_req = 1'b1;
        queue_item(CMD_COUNT, pick_bin());
        queue_item(CMD_COUNT, pick_bin());
        queue_item(CMD_FLUSH, $urandom());
      end
      queue_random(44);
      settle();
    end

    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
